// ===== rtl/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

  // Pool geometry and datapath widths.
  localparam int MAX_BLOCKS  = 256;
  localparam int ADDR_WIDTH  = 32;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W      = 17;
  localparam int TOTAL_W     = 32;
  localparam int PROD_W      = IDX_W + SIZE_W;
  localparam int DIV_STEP_W  = $clog2(ADDR_WIDTH);

  // Configuration port.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

  // Register values after reset.
  localparam logic [ADDR_WIDTH-1:0] BASE_RESET  = '0;
  localparam logic [SIZE_W-1:0]     SIZE_RESET  = SIZE_W'(64);
  localparam logic [CNT_W-1:0]      COUNT_RESET = CNT_W'(MAX_BLOCKS);

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NULL     = 3'd2,
    ST_INVALID  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Classification made by the front part.
  typedef enum logic [1:0] {
    JOB_ALLOC,
    JOB_FREE,
    JOB_NULL,
    JOB_INVALID
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] index;
  } job_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] base;
    logic [SIZE_W-1:0]     size;
    logic [CNT_W-1:0]      count;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] block_address;
    status_t               status;
    logic [CNT_W-1:0]      blocks_in_use;
    logic [CNT_W-1:0]      peak_in_use;
    logic [TOTAL_W-1:0]    total_allocated;
    logic [TOTAL_W-1:0]    total_freed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator.sv =====
// The front classifies one request at a time and holds full until the job
// is in the queue; a free must first pass the serial divider in the front part.
// The back carries out one job at a time through its result register.
// Reset clears all counters and sets the stack to its full, ordered state at
// once through per-entry written flags; no clearing pass is needed.
`default_nettype none

module fixed_block_pool_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode,
  input  logic [fbpa_pkg::ADDR_WIDTH-1:0]   free_address,
  output logic                              empty,
  input  logic                              pop,
  output logic [fbpa_pkg::ADDR_WIDTH-1:0]   block_address,
  output logic [2:0]                        status,
  output logic [fbpa_pkg::CNT_W-1:0]        blocks_in_use,
  output logic [fbpa_pkg::CNT_W-1:0]        peak_in_use,
  output logic [fbpa_pkg::TOTAL_W-1:0]      total_allocated,
  output logic [fbpa_pkg::TOTAL_W-1:0]      total_freed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fbpa_pkg::cfg_t                   cfg;
  logic                             refill;
  logic                             cfg_write;
  logic [fbpa_pkg::SIZE_W-1:0]      size_in;
  logic [fbpa_pkg::CNT_W-1:0]       count_in;
  logic                             job_push;
  logic                             job_full;
  fbpa_pkg::job_t                   job_in;
  logic                             job_pop;
  logic                             job_empty;
  fbpa_pkg::job_t                   job_out;
  logic                             res_valid;
  fbpa_pkg::result_t                res;
  logic                             out_pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Sizes and counts are truncated to their field widths here and clamped when written.
  assign size_in  = cfg_data[fbpa_pkg::SIZE_W-1:0];
  assign count_in = cfg_data[fbpa_pkg::CNT_W-1:0];

  // Configuration registers; a block count write requests a stack refill.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base  <= fbpa_pkg::BASE_RESET;
      cfg.size  <= fbpa_pkg::SIZE_RESET;
      cfg.count <= fbpa_pkg::COUNT_RESET;
      refill    <= 1'b0;
    end else begin
      refill <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          fbpa_pkg::REG_BASE_ADDRESS: begin
            cfg.base <= cfg_data[fbpa_pkg::ADDR_WIDTH-1:0];
          end
          fbpa_pkg::REG_BLOCK_SIZE: begin
            cfg.size <= (size_in == '0) ? fbpa_pkg::SIZE_W'(1) : size_in;
          end
          fbpa_pkg::REG_BLOCK_COUNT: begin
            if (count_in == '0) begin
              cfg.count <= fbpa_pkg::CNT_W'(1);
            end else if (count_in > fbpa_pkg::COUNT_RESET) begin
              cfg.count <= fbpa_pkg::COUNT_RESET;
            end else begin
              cfg.count <= count_in;
            end
            refill <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  fbpa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .free_address (free_address),
    .cfg          (cfg),
    .job_push     (job_push),
    .job_full     (job_full),
    .job          (job_in)
  );

  fbpa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .full    (job_full),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .empty   (job_empty),
    .rd_data (job_out)
  );

  fbpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .refill    (refill),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result side of the queue interface.
  assign empty   = !res_valid;
  assign out_pop = pop && res_valid;

  assign block_address   = res.block_address;
  assign status          = res.status;
  assign blocks_in_use   = res.blocks_in_use;
  assign peak_in_use     = res.peak_in_use;
  assign total_allocated = res.total_allocated;
  assign total_freed     = res.total_freed;

endmodule

`default_nettype wire

// ===== rtl/fbpa_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fbpa_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [fbpa_pkg::ADDR_WIDTH-1:0]   dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0]       divisor,
  output logic                              done,
  output logic [fbpa_pkg::ADDR_WIDTH-1:0]   quotient,
  output logic [fbpa_pkg::SIZE_W-1:0]       remainder
);

  logic                                busy;
  logic [fbpa_pkg::DIV_STEP_W-1:0]     step;
  logic [fbpa_pkg::ADDR_WIDTH-1:0]     quo;
  logic [fbpa_pkg::SIZE_W-1:0]         rem;
  logic [fbpa_pkg::SIZE_W-1:0]         dvs;
  logic [fbpa_pkg::SIZE_W:0]           rem_shift;
  logic [fbpa_pkg::SIZE_W:0]           rem_sub;
  logic                                fits;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    rem_shift = {rem, quo[fbpa_pkg::ADDR_WIDTH-1]};
    fits      = rem_shift >= {1'b0, dvs};
    rem_sub   = fits ? (rem_shift - {1'b0, dvs}) : rem_shift;
  end

  // Iteration control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo  <= {quo[fbpa_pkg::ADDR_WIDTH-2:0], fits};
        rem  <= rem_sub[fbpa_pkg::SIZE_W-1:0];
        step <= step + 1'b1;
        if (step == fbpa_pkg::DIV_STEP_W'(fbpa_pkg::ADDR_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/fbpa_front.sv =====
`default_nettype none

// Front part: takes requests and classifies them. A free with a non-null address
// goes through the divider to turn its offset into a block index and to check alignment.
module fbpa_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            opcode,
  input  logic [fbpa_pkg::ADDR_WIDTH-1:0] free_address,
  input  fbpa_pkg::cfg_t                  cfg,
  output logic                            job_push,
  input  logic                            job_full,
  output fbpa_pkg::job_t                  job
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIVIDE,
    F_SEND
  } front_state_t;

  front_state_t                     state;
  logic [fbpa_pkg::ADDR_WIDTH-1:0]  offset;
  logic                             div_start;
  logic                             div_done;
  logic [fbpa_pkg::ADDR_WIDTH-1:0]  div_quo;
  logic [fbpa_pkg::SIZE_W-1:0]      div_rem;

  // Offset from the pool base wraps around the address space.
  assign offset    = free_address - cfg.base;
  assign div_start = (state == F_IDLE) && push && (opcode == fbpa_pkg::OP_FREE) &&
                     (free_address != '0);

  fbpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (offset),
    .divisor   (cfg.size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Classification sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            job.index <= '0;
            if (opcode == fbpa_pkg::OP_ALLOC) begin
              job.kind <= fbpa_pkg::JOB_ALLOC;
              state    <= F_SEND;
            end else if (free_address == '0) begin
              job.kind <= fbpa_pkg::JOB_NULL;
              state    <= F_SEND;
            end else begin
              state <= F_DIVIDE;
            end
          end
        end
        F_DIVIDE: begin
          if (div_done) begin
            // The quotient is below the block count exactly when the offset
            // is inside the pool, since the remainder is below the size.
            job.index <= div_quo[fbpa_pkg::IDX_W-1:0];
            if ((div_rem != '0) ||
                (div_quo >= fbpa_pkg::ADDR_WIDTH'(cfg.count))) begin
              job.kind <= fbpa_pkg::JOB_INVALID;
            end else begin
              job.kind <= fbpa_pkg::JOB_FREE;
            end
            state <= F_SEND;
          end
        end
        F_SEND: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign full     = (state != F_IDLE);
  assign job_push = (state == F_SEND) && !job_full;

endmodule

`default_nettype wire

// ===== rtl/fbpa_queue.sv =====
`default_nettype none

// Short job queue that decouples the front and the back.
module fbpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  output logic           full,
  input  fbpa_pkg::job_t wr_data,
  input  logic           rd_en,
  output logic           empty,
  output fbpa_pkg::job_t rd_data
);

  localparam int PTR_W  = (fbpa_pkg::QUEUE_DEPTH > 1) ? $clog2(fbpa_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(fbpa_pkg::QUEUE_DEPTH + 1);

  fbpa_pkg::job_t    entries [fbpa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign full  = (fill == FILL_W'(fbpa_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  assign rd_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(fbpa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(fbpa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbpa_back.sv =====
`default_nettype none

// Back part: owns the free stack and the counters, and carries out one
// classified job at a time into the result register.
module fbpa_back (
  input  logic              clk,
  input  logic              rst,
  input  fbpa_pkg::cfg_t    cfg,
  input  logic              refill,
  input  logic              job_empty,
  input  fbpa_pkg::job_t    job,
  output logic              job_pop,
  input  logic              out_pop,
  output logic              res_valid,
  output fbpa_pkg::result_t res
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_ADD
  } back_state_t;

  back_state_t                        state;
  logic [fbpa_pkg::IDX_W-1:0]         stack [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0]    written;
  logic [fbpa_pkg::CNT_W-1:0]         top;
  logic [fbpa_pkg::CNT_W-1:0]         top_dec;
  logic [fbpa_pkg::CNT_W-1:0]         in_use;
  logic [fbpa_pkg::CNT_W-1:0]         in_use_inc;
  logic [fbpa_pkg::CNT_W-1:0]         in_use_dec;
  logic [fbpa_pkg::CNT_W-1:0]         peak;
  logic [fbpa_pkg::TOTAL_W-1:0]       alloc_total;
  logic [fbpa_pkg::TOTAL_W-1:0]       free_total;
  logic [fbpa_pkg::IDX_W-1:0]         rd_index;
  logic [fbpa_pkg::IDX_W-1:0]         rd_addr;
  logic [fbpa_pkg::IDX_W-1:0]         rd_data;
  logic                               rd_hit;
  logic [fbpa_pkg::IDX_W-1:0]         alloc_idx;
  logic [fbpa_pkg::PROD_W-1:0]        product;
  logic                               slot_free;
  logic                               take;
  logic                               mem_we;
  logic                               mem_re;

  assign slot_free = !res_valid || out_pop;
  assign take      = (state == B_IDLE) && !job_empty && slot_free;
  assign job_pop   = take;

  assign top_dec    = top - 1'b1;
  assign rd_index   = top_dec[fbpa_pkg::IDX_W-1:0];
  assign in_use_inc = in_use + 1'b1;
  assign in_use_dec = (in_use != '0) ? (in_use - 1'b1) : in_use;

  assign mem_we = take && (job.kind == fbpa_pkg::JOB_FREE) && (top < cfg.count);
  assign mem_re = take && (job.kind == fbpa_pkg::JOB_ALLOC) && (top != '0);

  // An entry never written since reset or refill holds its own index.
  assign alloc_idx = rd_hit ? rd_data : rd_addr;

  // Free stack storage with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack[top[fbpa_pkg::IDX_W-1:0]] <= job.index;
    end
    if (mem_re) begin
      rd_data <= stack[rd_index];
      rd_addr <= rd_index;
    end
  end

  // Written flags, cleared by reset and by a refill.
  always_ff @(posedge clk) begin
    if (rst || refill) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (mem_we) begin
        written[top[fbpa_pkg::IDX_W-1:0]] <= 1'b1;
      end
      if (mem_re) begin
        rd_hit <= written[rd_index];
      end
    end
  end

  // Job sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      res_valid   <= 1'b0;
      top         <= fbpa_pkg::COUNT_RESET;
      in_use      <= '0;
      peak        <= '0;
      alloc_total <= '0;
      free_total  <= '0;
    end else begin
      if (out_pop) begin
        res_valid <= 1'b0;
      end
      if (refill) begin
        top    <= cfg.count;
        in_use <= '0;
      end
      case (state)
        B_IDLE: begin
          if (take) begin
            // Default result fields: current counters, no address.
            res.block_address   <= '0;
            res.blocks_in_use   <= in_use;
            res.peak_in_use     <= peak;
            res.total_allocated <= alloc_total;
            res.total_freed     <= free_total;
            case (job.kind)
              fbpa_pkg::JOB_ALLOC: begin
                if (top == '0) begin
                  res.status <= fbpa_pkg::ST_EMPTY;
                  res_valid  <= 1'b1;
                end else begin
                  top   <= top_dec;
                  state <= B_READ;
                end
              end
              fbpa_pkg::JOB_FREE: begin
                if (top >= cfg.count) begin
                  res.status <= fbpa_pkg::ST_OVERFLOW;
                end else begin
                  top               <= top + 1'b1;
                  in_use            <= in_use_dec;
                  free_total        <= free_total + 1'b1;
                  res.blocks_in_use <= in_use_dec;
                  res.total_freed   <= free_total + 1'b1;
                  res.status        <= fbpa_pkg::ST_OK;
                end
                res_valid <= 1'b1;
              end
              fbpa_pkg::JOB_NULL: begin
                res.status <= fbpa_pkg::ST_NULL;
                res_valid  <= 1'b1;
              end
              default: begin
                res.status <= fbpa_pkg::ST_INVALID;
                res_valid  <= 1'b1;
              end
            endcase
          end
        end
        B_READ: begin
          // Block offset from the popped index.
          product <= {{fbpa_pkg::SIZE_W{1'b0}}, alloc_idx} *
                     {{fbpa_pkg::IDX_W{1'b0}}, cfg.size};
          state   <= B_ADD;
        end
        B_ADD: begin
          res.block_address   <= cfg.base + fbpa_pkg::ADDR_WIDTH'(product);
          res.status          <= fbpa_pkg::ST_OK;
          res.blocks_in_use   <= in_use_inc;
          res.peak_in_use     <= (in_use_inc > peak) ? in_use_inc : peak;
          res.total_allocated <= alloc_total + 1'b1;
          in_use              <= in_use_inc;
          peak                <= (in_use_inc > peak) ? in_use_inc : peak;
          alloc_total         <= alloc_total + 1'b1;
          res_valid           <= 1'b1;
          state               <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
